[rtl/core/float_square_root_top_defines.svh]
`ifndef FLOAT_SQUARE_ROOT_TOP_DEFINES_SVH
`define FLOAT_SQUARE_ROOT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fsr_pkg.sv]
`default_nettype none

package fsr_pkg;

    // positive normal float: biased exponent, significand with hidden one
    typedef struct packed {
        logic [7:0]  e;
        logic [23:0] m;
    } fp_t;

    // travels with each word: original operand and current estimate
    typedef struct packed {
        logic [31:0] op;
        fp_t         y;
    } tag_t;

    localparam int NEWTON_STEPS = 3;

    localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;
    localparam logic [31:0] SEED_C0     = 32'h3ED5_A9A8;  // 0.41731f
    localparam logic [31:0] SEED_C1     = 32'h3F17_14BA;  // 0.59016f
    localparam logic [31:0] RSQRT2_BITS = 32'h3F35_04F3;  // sqrt(0.5)

    localparam int DIV_QBITS      = 25;
    localparam int DIV_STEP_BITS  = 4;
    localparam int DIV_STAGES     = (DIV_QBITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

    function automatic fp_t to_fp(input logic [31:0] b);
        fp_t r;
        r.e = b[30:23];
        r.m = {1'b1, b[22:0]};
        return r;
    endfunction

    // significand of the operand scaled into [0.5,1)
    function automatic fp_t op_frac(input logic [31:0] b);
        fp_t r;
        r.e = 8'd126;
        r.m = {1'b1, b[22:0]};
        return r;
    endfunction

    // round to nearest even
    function automatic fp_t round_pack(input logic [7:0] e, input logic [23:0] m,
                                       input logic g, input logic st);
        logic        inc;
        logic [24:0] sum;
        fp_t         r;
        inc = g & (st | m[0]);
        sum = {1'b0, m} + {24'd0, inc};
        if (sum[24])
        begin
            r.e = e + 8'd1;
            r.m = sum[24:1];
        end
        else
        begin
            r.e = e;
            r.m = sum[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fsr_fmul.sv]
`default_nettype none

module fsr_fmul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire fsr_pkg::fp_t  a,
    input  wire fsr_pkg::fp_t  b,
    input  wire fsr_pkg::tag_t in_tag,
    output logic               out_valid,
    output fsr_pkg::fp_t       p,
    output fsr_pkg::tag_t      out_tag
);
    import fsr_pkg::*;

    logic        v1_reg;
    logic [47:0] prod_reg;
    logic [9:0]  esum_reg;
    tag_t        tag1_reg;
    logic [47:0] prod_next;
    logic [9:0]  esum_next;

    logic        v2_reg;
    fp_t         p_reg;
    tag_t        tag2_reg;
    fp_t         p_next;
    logic [9:0]  e_adj;

    assign prod_next = {24'd0, a.m} * {24'd0, b.m};
    assign esum_next = {2'b00, a.e} + {2'b00, b.e} - 10'd127;

    always_comb
    begin
        e_adj = esum_reg + 10'd1;
        if (prod_reg[47])
            p_next = round_pack(e_adj[7:0], prod_reg[47:24], prod_reg[23],
                                |prod_reg[22:0]);
        else
            p_next = round_pack(esum_reg[7:0], prod_reg[46:23], prod_reg[22],
                                |prod_reg[21:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            esum_reg <= esum_next;
            tag1_reg <= in_tag;
            p_reg    <= p_next;
            tag2_reg <= tag1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign p         = p_reg;
    assign out_tag   = tag2_reg;

endmodule

`default_nettype wire

[rtl/core/fsr_fadd.sv]
`default_nettype none

module fsr_fadd (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire fsr_pkg::fp_t  a,
    input  wire fsr_pkg::fp_t  b,
    input  wire fsr_pkg::tag_t in_tag,
    output logic               out_valid,
    output fsr_pkg::fp_t       s,
    output fsr_pkg::tag_t      out_tag
);
    import fsr_pkg::*;

    // align stage
    fp_t         big;
    fp_t         sml;
    logic [7:0]  d;
    logic [26:0] ext;
    logic [26:0] mask;
    logic [26:0] al_next;

    logic        v1_reg;
    logic [7:0]  e_reg;
    logic [26:0] am_reg;
    logic [26:0] bm_reg;
    tag_t        tag1_reg;

    // add and round stage
    logic [27:0] sum;
    logic [7:0]  e_inc;
    fp_t         s_next;

    logic        v2_reg;
    fp_t         s_reg;
    tag_t        tag2_reg;

    always_comb
    begin
        if ((a.e > b.e) || ((a.e == b.e) && (a.m >= b.m)))
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        d    = big.e - sml.e;
        ext  = {sml.m, 3'b000};
        mask = (27'd1 << d[4:0]) - 27'd1;
        if (d >= 8'd27)
            al_next = 27'd1;
        else
            al_next = (ext >> d[4:0]) | {26'd0, |(ext & mask)};
    end

    always_comb
    begin
        sum   = {1'b0, am_reg} + {1'b0, bm_reg};
        e_inc = e_reg + 8'd1;
        if (sum[27])
            s_next = round_pack(e_inc, sum[27:4], sum[3], |sum[2:0]);
        else
            s_next = round_pack(e_reg, sum[26:3], sum[2], |sum[1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg    <= big.e;
            am_reg   <= {big.m, 3'b000};
            bm_reg   <= al_next;
            tag1_reg <= in_tag;
            s_reg    <= s_next;
            tag2_reg <= tag1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign s         = s_reg;
    assign out_tag   = tag2_reg;

endmodule

`default_nettype wire

[rtl/core/fsr_fdiv.sv]
`default_nettype none

module fsr_fdiv (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire fsr_pkg::fp_t  a,
    input  wire fsr_pkg::fp_t  b,
    input  wire fsr_pkg::tag_t in_tag,
    output logic               out_valid,
    output fsr_pkg::fp_t       q,
    output fsr_pkg::tag_t      out_tag
);
    import fsr_pkg::*;

    // stage k output, k = 0 is the setup stage
    logic              st_v   [DIV_STAGES+1];
    logic [25:0]       st_r   [DIV_STAGES+1];
    logic [23:0]       st_d   [DIV_STAGES+1];
    logic [7:0]        st_e   [DIV_STAGES+1];
    logic [24:0]       st_q   [DIV_STAGES+1];
    tag_t              st_tag [DIV_STAGES+1];

    logic        v0_reg;
    logic [25:0] r0_reg;
    logic [23:0] d0_reg;
    logic [7:0]  e0_reg;
    tag_t        tag0_reg;
    logic [25:0] r0_next;
    logic [9:0]  e0_next;

    always_comb
    begin
        if (a.m >= b.m)
        begin
            r0_next = {2'b00, a.m};
            e0_next = {2'b00, a.e} - {2'b00, b.e} + 10'd127;
        end
        else
        begin
            r0_next = {1'b0, a.m, 1'b0};
            e0_next = {2'b00, a.e} - {2'b00, b.e} + 10'd126;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg   <= r0_next;
            d0_reg   <= b.m;
            e0_reg   <= e0_next[7:0];
            tag0_reg <= in_tag;
        end
    end

    assign st_v[0]   = v0_reg;
    assign st_r[0]   = r0_reg;
    assign st_d[0]   = d0_reg;
    assign st_e[0]   = e0_reg;
    assign st_q[0]   = '0;
    assign st_tag[0] = tag0_reg;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_step
        logic        v_reg;
        logic [25:0] r_reg;
        logic [23:0] d_reg;
        logic [7:0]  e_reg;
        logic [24:0] q_reg;
        tag_t        tag_reg;
        logic [25:0] r_next;
        logic [24:0] q_next;

        // restoring division, one quotient bit per step
        always_comb
        begin
            r_next = st_r[s];
            q_next = st_q[s];
            for (int k = 0; k < DIV_STEP_BITS; k++)
            begin
                if ((s * DIV_STEP_BITS + k) < DIV_QBITS)
                begin
                    if (r_next >= {2'b00, st_d[s]})
                    begin
                        r_next = r_next - {2'b00, st_d[s]};
                        q_next = {q_next[23:0], 1'b1};
                    end
                    else
                    begin
                        q_next = {q_next[23:0], 1'b0};
                    end
                    r_next = {r_next[24:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= st_v[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg   <= r_next;
                d_reg   <= st_d[s];
                e_reg   <= st_e[s];
                q_reg   <= q_next;
                tag_reg <= st_tag[s];
            end
        end

        assign st_v[s+1]   = v_reg;
        assign st_r[s+1]   = r_reg;
        assign st_d[s+1]   = d_reg;
        assign st_e[s+1]   = e_reg;
        assign st_q[s+1]   = q_reg;
        assign st_tag[s+1] = tag_reg;
    end

    logic vf_reg;
    fp_t  qf_reg;
    tag_t tagf_reg;
    fp_t  qf_next;

    assign qf_next = round_pack(st_e[DIV_STAGES], st_q[DIV_STAGES][24:1],
                                st_q[DIV_STAGES][0], |st_r[DIV_STAGES]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (adv)
            vf_reg <= st_v[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qf_reg   <= qf_next;
            tagf_reg <= st_tag[DIV_STAGES];
        end
    end

    assign out_valid = vf_reg;
    assign q         = qf_reg;
    assign out_tag   = tagf_reg;

endmodule

`default_nettype wire

[rtl/core/fsr_newton.sv]
`default_nettype none

module fsr_newton (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire fsr_pkg::tag_t in_tag,
    output logic               out_valid,
    output fsr_pkg::tag_t      out_tag
);
    import fsr_pkg::*;

    logic div_valid;
    fp_t  quo;
    tag_t div_tag;
    logic add_valid;
    fp_t  sum;
    tag_t add_tag;

    // y' = 0.5 * (y + f / y)
    fsr_fdiv u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .a         (op_frac(in_tag.op)),
        .b         (in_tag.y),
        .in_tag    (in_tag),
        .out_valid (div_valid),
        .q         (quo),
        .out_tag   (div_tag)
    );

    fsr_fadd u_add (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .a         (div_tag.y),
        .b         (quo),
        .in_tag    (div_tag),
        .out_valid (add_valid),
        .s         (sum),
        .out_tag   (add_tag)
    );

    assign out_valid    = add_valid;
    assign out_tag.op   = add_tag.op;
    assign out_tag.y.e  = sum.e - 8'd1;
    assign out_tag.y.m  = sum.m;

endmodule

`default_nettype wire

[rtl/core/float_square_root_top.sv]
// Square root of a binary32 word, fully pipelined.
// Path from operand accept to root_valid: seed, each Newton step through the
// 25-bit divider, scale, pack. Throughput: one word per cycle while the skid
// is empty; a two-entry output skid decouples the sides.
// Reset: rst_n asynchronous, active low, clears all valid bits; no data reset.
`default_nettype none

module float_square_root_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] operand_bits,
    input  wire logic        operand_valid,
    output logic             operand_ready,
    output logic [31:0]      root_bits,
    output logic             root_valid,
    input  wire logic        root_ready
);
    import fsr_pkg::*;

    logic        adv;
    tag_t        in_tag;

    logic        t_valid;
    fp_t         t_val;
    tag_t        t_tag;
    logic        s_valid;
    fp_t         s_val;
    tag_t        s_tag;

    logic        nv   [NEWTON_STEPS+1];
    tag_t        ntag [NEWTON_STEPS+1];

    logic        m_valid;
    fp_t         m_val;
    tag_t        m_tag;

    logic [31:0] res;
    logic [7:0]  bexp;
    logic        odd;
    fp_t         ysel;
    logic [9:0]  nsum;
    logic [9:0]  half;
    logic [10:0] enew;

    logic        out_valid_reg;
    logic [31:0] out_reg;
    logic        skid_valid_reg;
    logic [31:0] skid_reg;
    logic        out_valid_next;
    logic [31:0] out_next;
    logic        skid_valid_next;
    logic [31:0] skid_next;

    assign adv           = !skid_valid_reg;
    assign operand_ready = adv;
    assign in_tag.op     = operand_bits;
    assign in_tag.y      = '0;

    fsr_fmul u_seed_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (operand_valid),
        .a         (op_frac(operand_bits)),
        .b         (to_fp(SEED_C1)),
        .in_tag    (in_tag),
        .out_valid (t_valid),
        .p         (t_val),
        .out_tag   (t_tag)
    );

    fsr_fadd u_seed_add (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t_valid),
        .a         (to_fp(SEED_C0)),
        .b         (t_val),
        .in_tag    (t_tag),
        .out_valid (s_valid),
        .s         (s_val),
        .out_tag   (s_tag)
    );

    assign nv[0]      = s_valid;
    assign ntag[0].op = s_tag.op;
    assign ntag[0].y  = s_val;

    for (genvar i = 0; i < NEWTON_STEPS; i++)
    begin : g_newton
        fsr_newton u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (nv[i]),
            .in_tag    (ntag[i]),
            .out_valid (nv[i+1]),
            .out_tag   (ntag[i+1])
        );
    end

    fsr_fmul u_scale_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nv[NEWTON_STEPS]),
        .a         (ntag[NEWTON_STEPS].y),
        .b         (to_fp(RSQRT2_BITS)),
        .in_tag    (ntag[NEWTON_STEPS]),
        .out_valid (m_valid),
        .p         (m_val),
        .out_tag   (m_tag)
    );

    // exponent fix-up and special operands
    always_comb
    begin
        bexp = m_tag.op[30:23];
        odd  = bexp[0];
        ysel = odd ? m_val : m_tag.y;
        nsum = {2'b00, bexp} - 10'd126 + {9'd0, odd};
        half = {nsum[9], nsum[9:1]};
        enew = {3'b000, ysel.e} + {half[9], half};
        if ($signed(enew) < $signed(11'd1))
            enew = 11'd1;
        else if ($signed(enew) > $signed(11'd254))
            enew = 11'd254;
        if (bexp == 8'hFF)
        begin
            if (m_tag.op[22:0] != 23'd0)
                res = m_tag.op;
            else
                res = m_tag.op[31] ? QNAN_BITS : m_tag.op;
        end
        else if (bexp == 8'h00)
            res = {m_tag.op[31], 31'd0};
        else if (m_tag.op[31])
            res = QNAN_BITS;
        else
            res = {1'b0, enew[7:0], ysel.m[22:0]};
    end

    // output register with skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (adv)
        begin
            if (!out_valid_reg || root_ready)
            begin
                out_valid_next = m_valid;
                if (m_valid)
                    out_next = res;
            end
            else if (m_valid)
            begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
        else if (root_ready)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign root_valid = out_valid_reg;
    assign root_bits  = out_reg;

endmodule

`default_nettype wire

[rtl/core/fsr_checker.sv]
`default_nettype none

`include "float_square_root_top_defines.svh"

module fsr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        operand_ready,
    input wire logic [31:0] root_bits,
    input wire logic        root_valid,
    input wire logic        root_ready
);

    `FSR_ASSERT_NEXT(a_out_hold, root_valid && !root_ready, root_valid && $stable(root_bits), "root word changed while stalled")
    `FSR_ASSERT_NOW(a_full_out, !operand_ready, root_valid, "input blocked with no word at output")
    `FSR_ASSERT_NEXT(a_skid_keep, !operand_ready && !root_ready, !operand_ready, "skid emptied without a take")
    `FSR_ASSERT_NEXT(a_skid_drain, !operand_ready && root_ready, operand_ready && root_valid, "skid did not drain on take")

endmodule

bind float_square_root_top fsr_checker u_fsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_ready (operand_ready),
    .root_bits     (root_bits),
    .root_valid    (root_valid),
    .root_ready    (root_ready)
);

`default_nettype wire

[bench/float_square_root_top_tb.sv]
`timescale 1ns / 1ps

module float_square_root_top_tb;
    import fsr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic [31:0] operand_bits;
    logic        operand_valid;
    logic        operand_ready;
    logic [31:0] root_bits;
    logic        root_valid;
    logic        root_ready;

    typedef struct {
        logic [31:0] op;
        logic [31:0] root;
        bit          typed;
    } row_t;

    logic [31:0] expected_roots[$];
    int          errors;
    int          words_sent;
    int          words_checked;
    bit          quiet_mode;

    float_square_root_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .operand_bits (operand_bits),
        .operand_valid(operand_valid),
        .operand_ready(operand_ready),
        .root_bits    (root_bits),
        .root_valid   (root_valid),
        .root_ready   (root_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // value = v * 2^k, v > 2^25; round to nearest even into binary32 bits
    function automatic logic [31:0] round_to_single(input logic [63:0] v, input int k);
        int          p;
        int          e;
        logic [63:0] m;
        logic        g;
        logic        st;
        p = 63;
        while (!v[p])
            p--;
        e = p + k + 127;
        m = v >> (p - 23);
        g = v[p - 24];
        st = (v & ((64'd1 << (p - 24)) - 64'd1)) != 64'd0;
        if (g && (st || m[0]))
            m = m + 64'd1;
        if (m[24])
        begin
            m = m >> 1;
            e++;
        end
        return {1'b0, e[7:0], m[22:0]};
    endfunction

    // positive normal operands only
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] v;
        v = {40'd0, 1'b1, a[22:0]} * {40'd0, 1'b1, b[22:0]};
        return round_to_single(v, int'(a[30:23]) + int'(b[30:23]) - 300);
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [63:0] vh;
        logic [63:0] vl;
        int          d;
        if (a[30:0] >= b[30:0])
        begin
            hi = a;
            lo = b;
        end
        else
        begin
            hi = b;
            lo = a;
        end
        d = int'(hi[30:23]) - int'(lo[30:23]);
        vh = {40'd0, 1'b1, hi[22:0]} << 32;
        vl = {40'd0, 1'b1, lo[22:0]} << 32;
        if (d > 55)
            vl = 64'd1;
        else if (d > 0)
            vl = (vl >> d) | ((vl & ((64'd1 << d) - 64'd1)) != 64'd0);
        return round_to_single(vh + vl, int'(hi[30:23]) - 182);
    endfunction

    function automatic logic [31:0] fdiv(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        num = {40'd0, 1'b1, a[22:0]} << 39;
        den = {40'd0, 1'b1, b[22:0]};
        q = num / den;
        if (num % den != 64'd0)
            q[0] = 1'b1;
        return round_to_single(q, int'(a[30:23]) - int'(b[30:23]) - 39);
    endfunction

    function automatic logic [31:0] predict_root(input logic [31:0] x);
        logic [31:0] f;
        logic [31:0] y;
        int          n;
        int          e;
        if (x[30:23] == 8'hFF)
        begin
            if (x[22:0] != 23'd0)
                return x;
            return x[31] ? QNAN_BITS : x;
        end
        if (x[30:23] == 8'd0)
            return {x[31], 31'd0};
        if (x[31])
            return QNAN_BITS;
        n = int'(x[30:23]) - 126;
        f = {1'b0, 8'd126, x[22:0]};
        y = fadd(SEED_C0, fmul(SEED_C1, f));
        for (int i = 0; i < NEWTON_STEPS; i++)
            y = fmul(32'h3F00_0000, fadd(y, fdiv(f, y)));
        if (x[23])
        begin
            y = fmul(y, RSQRT2_BITS);
            n = n + 1;
        end
        e = int'(y[30:23]) + n / 2;
        if (e < 1)
            e = 1;
        if (e > 254)
            e = 254;
        return {y[31], e[7:0], y[22:0]};
    endfunction

    function automatic int pick_gap();
        if (quiet_mode)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic send_word(input logic [31:0] x, input logic [31:0] root);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            operand_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_valid <= 1'b1;
        operand_bits <= x;
        @(posedge clk);
        while (!operand_ready)
            @(posedge clk);
        expected_roots.push_back(root);
        words_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            root_ready <= quiet_mode ? 1'b1 : ($urandom_range(0, 30) == 0) ? 1'b0
                          : ($urandom_range(0, 3) != 0);
        if (rst_n && root_valid && root_ready)
        begin
            if (expected_roots.size() == 0)
            begin
                $error("root_bits: unexpected word %h", root_bits);
                errors++;
            end
            else
            begin
                if (root_bits !== expected_roots[0])
                begin
                    $error("root_bits: expected %h actual %h", expected_roots[0], root_bits);
                    errors++;
                end
                void'(expected_roots.pop_front());
                words_checked++;
            end
        end
    end

    initial
    begin
        row_t        rows[$];
        logic [31:0] x;
        int          wait_cycles;
        rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b1},
            '{32'h8000_0000, 32'h8000_0000, 1'b1},
            '{32'h7F80_0000, 32'h7F80_0000, 1'b1},
            '{32'hFF80_0000, QNAN_BITS,     1'b1},
            '{32'h7FC0_0001, 32'h7FC0_0001, 1'b1},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
            '{32'h7F80_0001, 32'h7F80_0001, 1'b1},
            '{32'h0000_0001, 32'h0000_0000, 1'b1},
            '{32'h007F_FFFF, 32'h0000_0000, 1'b1},
            '{32'h807F_FFFF, 32'h8000_0000, 1'b1},
            '{32'hBF80_0000, QNAN_BITS,     1'b1},
            '{32'h8080_0000, QNAN_BITS,     1'b1},
            '{32'h3F80_0000, 32'h0,         1'b0},
            '{32'h4000_0000, 32'h0,         1'b0},
            '{32'h4080_0000, 32'h0,         1'b0},
            '{32'h3F7F_FFFF, 32'h0,         1'b0},
            '{32'h7F7F_FFFF, 32'h0,         1'b0},
            '{32'h0080_0000, 32'h0,         1'b0},
            '{32'h0100_0000, 32'h0,         1'b0},
            '{32'h40C0_0000, 32'h0,         1'b0},
            '{32'h3FFF_FFFF, 32'h0,         1'b0}
        };
        rst_n = 1'b0;
        operand_bits = 32'd0;
        operand_valid = 1'b0;
        root_ready = 1'b0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        quiet_mode = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].op, rows[i].typed ? rows[i].root : predict_root(rows[i].op));

        for (int i = 0; i < 850; i++)
        begin
            if (i % 100 == 0)
                quiet_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) < 7)
                x = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
            else
                x = $urandom;
            send_word(x, predict_root(x));
        end
        operand_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_roots.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (60) @(posedge clk);
        if (expected_roots.size() != 0)
        begin
            $error("root_bits: %0d words never arrived", expected_roots.size());
            errors++;
        end
        $display("Sent %0d operands (specials, extremes, random), checked %0d roots,",
                 words_sent, words_checked);
        $display("with random gaps and stalls on both sides; %0d mismatches.", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
